/* design/segment_intersection_test_2d_top_macros.svh */
// Assertion helpers for the segment intersection block
`ifndef SEGMENT_INTERSECTION_TEST_2D_TOP_MACROS_SVH
`define SEGMENT_INTERSECTION_TEST_2D_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SIT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sit: check failed");
`define SIT_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sit: check failed");
`else
`define SIT_ASSERT_IMP(label, clk, rst, ante, cons)
`define SIT_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* design/sit_pkg.sv */
`default_nettype none
package sit_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int QUEUE_DEPTH    = 4;
  localparam int Q_BITS         = 32;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_POINT = 2'd1;
  localparam logic [1:0] KIND_DIV   = 2'd2;

  typedef struct packed {
    logic       hit;
    logic [1:0] kind;
  } sit_ctrl_t;

  function automatic int num_w(input int cw);
    return 2 * (cw + 1) + 1;
  endfunction

  function automatic int quo_w(input int cw, input int fb);
    return ((cw + fb) > Q_BITS ? cw + fb : Q_BITS) + 1;
  endfunction

  function automatic int entry_w(input int cw);
    return 2 * cw + 2 * (cw + 1) + 2 * num_w(cw);
  endfunction

endpackage
`default_nettype wire

/* design/sit_fifo.sv */
`default_nettype none
`include "segment_intersection_test_2d_top_macros.svh"
module sit_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = sit_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW  = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int CNW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CNW-1:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign full  = (count == CNW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  `SIT_ASSERT_IMP(a_no_overfill, clk, rst, push, count != CNW'(DEPTH))
  `SIT_ASSERT_IMP(a_no_underrun, clk, rst, pop, count != '0)
  `SIT_ASSERT_NXT(a_count_up, clk, rst, push && !pop, count == CNW'($past(count) + 1'b1))

endmodule
`default_nettype wire

/* design/sit_front.sv */
`default_nettype none
module sit_front #(
  parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_valid,
  output logic                    item_stall,
  input  logic signed [COORD_BITS-1:0] ax,
  input  logic signed [COORD_BITS-1:0] ay,
  input  logic signed [COORD_BITS-1:0] bx,
  input  logic signed [COORD_BITS-1:0] by,
  input  logic signed [COORD_BITS-1:0] cx,
  input  logic signed [COORD_BITS-1:0] cy,
  input  logic signed [COORD_BITS-1:0] dx,
  input  logic signed [COORD_BITS-1:0] dy,
  input  logic                    want_point,
  input  logic                    full,
  output logic                    push,
  output sit_pkg::sit_ctrl_t      ctrl,
  output logic [sit_pkg::entry_w(COORD_BITS)-1:0] entry
);
  import sit_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;
  localparam int NW = num_w(CW);

  logic en;
  logic v1, v2, v3;

  // stage 1: coordinates and edge vectors
  logic signed [CW-1:0] s1_x [4];
  logic signed [CW-1:0] s1_y [4];
  logic                 s1_want;
  logic signed [DW-1:0] s1_bax, s1_bay, s1_cax, s1_cay, s1_dax, s1_day;
  logic signed [DW-1:0] s1_cbx, s1_cby, s1_dbx, s1_dby, s1_cdx, s1_cdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= item_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_x[0] <= ax; s1_y[0] <= ay;
      s1_x[1] <= bx; s1_y[1] <= by;
      s1_x[2] <= cx; s1_y[2] <= cy;
      s1_x[3] <= dx; s1_y[3] <= dy;
      s1_want <= want_point;
      s1_bax  <= DW'(bx) - DW'(ax);
      s1_bay  <= DW'(by) - DW'(ay);
      s1_cax  <= DW'(cx) - DW'(ax);
      s1_cay  <= DW'(cy) - DW'(ay);
      s1_dax  <= DW'(dx) - DW'(ax);
      s1_day  <= DW'(dy) - DW'(ay);
      s1_cbx  <= DW'(cx) - DW'(bx);
      s1_cby  <= DW'(cy) - DW'(by);
      s1_dbx  <= DW'(dx) - DW'(bx);
      s1_dby  <= DW'(dy) - DW'(by);
      s1_cdx  <= DW'(cx) - DW'(dx);
      s1_cdy  <= DW'(cy) - DW'(dy);
    end
  end

  // second-smallest endpoint in (x, y) order, ties kept in input order
  logic [2*CW-1:0]      key  [4];
  logic [1:0]           rank [4];
  logic signed [CW-1:0] sel_x, sel_y;
  logic                 x_apart, y_apart, shared_ok;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      key[i] = {~s1_x[i][CW-1], s1_x[i][CW-2:0], ~s1_y[i][CW-1], s1_y[i][CW-2:0]};
    end
    for (int i = 0; i < 4; i++) begin
      rank[i] = 2'd0;
      for (int j = 0; j < 4; j++) begin
        if (j != i && (key[j] < key[i] || (j < i && key[j] == key[i]))) begin
          rank[i] = rank[i] + 2'd1;
        end
      end
    end
    sel_x = s1_x[0];
    sel_y = s1_y[0];
    for (int i = 0; i < 4; i++) begin
      if (rank[i] == 2'd1) begin
        sel_x = s1_x[i];
        sel_y = s1_y[i];
      end
    end
  end

  assign x_apart = (s1_x[0] <= s1_x[2] && s1_x[0] <= s1_x[3] &&
                    s1_x[1] <= s1_x[2] && s1_x[1] <= s1_x[3]) ||
                   (s1_x[0] >= s1_x[2] && s1_x[0] >= s1_x[3] &&
                    s1_x[1] >= s1_x[2] && s1_x[1] >= s1_x[3]);
  assign y_apart = (s1_y[0] <= s1_y[2] && s1_y[0] <= s1_y[3] &&
                    s1_y[1] <= s1_y[2] && s1_y[1] <= s1_y[3]) ||
                   (s1_y[0] >= s1_y[2] && s1_y[0] >= s1_y[3] &&
                    s1_y[1] >= s1_y[2] && s1_y[1] >= s1_y[3]);
  assign shared_ok =
    ((s1_x[0] == s1_x[2] && s1_y[0] == s1_y[2]) == (s1_x[1] == s1_x[3] && s1_y[1] == s1_y[3])) &&
    ((s1_x[0] == s1_x[3] && s1_y[0] == s1_y[3]) == (s1_x[1] == s1_x[2] && s1_y[1] == s1_y[2]));

  // stage 2: cross products
  logic signed [PW-1:0] s2_abc1, s2_abc2, s2_bcd1, s2_bcd2, s2_abd1, s2_abd2;
  logic signed [PW-1:0] s2_acd1, s2_acd2, s2_det1, s2_det2, s2_num1, s2_num2;
  logic signed [CW-1:0] s2_ax, s2_ay, s2_sel_x, s2_sel_y;
  logic signed [DW-1:0] s2_dirx, s2_diry;
  logic                 s2_apart, s2_shared, s2_want;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_abc1   <= s1_bax * s1_cay;
      s2_abc2   <= s1_bay * s1_cax;
      s2_bcd1   <= s1_cbx * s1_dby;
      s2_bcd2   <= s1_cby * s1_dbx;
      s2_abd1   <= s1_bax * s1_day;
      s2_abd2   <= s1_bay * s1_dax;
      s2_acd1   <= s1_cax * s1_day;
      s2_acd2   <= s1_cay * s1_dax;
      s2_det1   <= s1_bax * s1_cdy;
      s2_det2   <= s1_cdx * s1_bay;
      s2_num1   <= s1_cax * s1_cdy;
      s2_num2   <= s1_cdx * s1_cay;
      s2_ax     <= s1_x[0];
      s2_ay     <= s1_y[0];
      s2_sel_x  <= sel_x;
      s2_sel_y  <= sel_y;
      s2_dirx   <= s1_bax;
      s2_diry   <= s1_bay;
      s2_apart  <= x_apart && y_apart;
      s2_shared <= shared_ok;
      s2_want   <= s1_want;
    end
  end

  // stage 3: orientation signs, determinant and numerator
  logic [1:0]           s3_abc, s3_bcd, s3_abd, s3_acd;
  logic signed [NW-1:0] s3_det, s3_num;
  logic signed [CW-1:0] s3_ax, s3_ay, s3_sel_x, s3_sel_y;
  logic signed [DW-1:0] s3_dirx, s3_diry;
  logic                 s3_apart, s3_shared, s3_want;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_abc    <= {s2_abc1 > s2_abc2, s2_abc1 < s2_abc2};
      s3_bcd    <= {s2_bcd1 > s2_bcd2, s2_bcd1 < s2_bcd2};
      s3_abd    <= {s2_abd1 > s2_abd2, s2_abd1 < s2_abd2};
      s3_acd    <= {s2_acd1 > s2_acd2, s2_acd1 < s2_acd2};
      s3_det    <= NW'(s2_det1) - NW'(s2_det2);
      s3_num    <= NW'(s2_num1) - NW'(s2_num2);
      s3_ax     <= s2_ax;
      s3_ay     <= s2_ay;
      s3_sel_x  <= s2_sel_x;
      s3_sel_y  <= s2_sel_y;
      s3_dirx   <= s2_dirx;
      s3_diry   <= s2_diry;
      s3_apart  <= s2_apart;
      s3_shared <= s2_shared;
      s3_want   <= s2_want;
    end
  end

  logic all_zero, hit_gen;
  assign all_zero = ~|{s3_abc, s3_bcd, s3_abd, s3_acd};
  assign hit_gen  = (s3_abc != s3_abd) && (s3_bcd != s3_acd);

  always_comb begin
    priority if (all_zero) begin
      ctrl.hit  = !s3_apart;
      ctrl.kind = s3_apart ? KIND_NONE : KIND_POINT;
    end else if (s3_shared) begin
      ctrl.hit  = hit_gen;
      ctrl.kind = (s3_want && s3_det != '0) ? KIND_DIV : KIND_NONE;
    end else begin
      ctrl.hit  = 1'b0;
      ctrl.kind = KIND_NONE;
    end
  end

  assign entry = {all_zero ? s3_sel_x : s3_ax, all_zero ? s3_sel_y : s3_ay,
                  s3_dirx, s3_diry, s3_num, s3_det};

  assign push       = v3 && !full;
  assign en         = !(v3 && full);
  assign item_stall = !en;

endmodule
`default_nettype wire

/* design/sit_div.sv */
`default_nettype none
module sit_div #(
  parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = sit_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic en,
  input  logic [sit_pkg::quo_w(COORD_BITS, FRAC_BITS)+sit_pkg::num_w(COORD_BITS)-1:0] dividend,
  input  logic [sit_pkg::num_w(COORD_BITS)-1:0] divisor,
  output logic [sit_pkg::quo_w(COORD_BITS, FRAC_BITS)-1:0] quot,
  output logic rem_nz,
  output logic ovf
);
  import sit_pkg::*;

  localparam int NW = num_w(COORD_BITS);
  localparam int QW = quo_w(COORD_BITS, FRAC_BITS);
  localparam int XW = QW + NW;

  logic [NW-1:0] r    [QW+1];
  logic [QW-1:0] lo   [QW+1];
  logic [QW-1:0] qq   [QW+1];
  logic [NW-1:0] dd   [QW+1];
  logic          ov   [QW+1];
  logic [NW:0]   part [QW];
  logic          ge   [QW];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      part[k] = {r[k], lo[k][QW-1]};
      ge[k]   = part[k] >= {1'b0, dd[k]};
    end
  end

  // one quotient bit per stage, restoring
  always_ff @(posedge clk) begin
    if (en) begin
      r[0]  <= dividend[XW-1:QW];
      lo[0] <= dividend[QW-1:0];
      qq[0] <= '0;
      dd[0] <= divisor;
      ov[0] <= dividend[XW-1:QW] >= divisor;
      for (int k = 1; k <= QW; k++) begin
        r[k]  <= ge[k-1] ? NW'(part[k-1] - {1'b0, dd[k-1]}) : part[k-1][NW-1:0];
        lo[k] <= {lo[k-1][QW-2:0], 1'b0};
        qq[k] <= {qq[k-1][QW-2:0], ge[k-1]};
        dd[k] <= dd[k-1];
        ov[k] <= ov[k-1];
      end
    end
  end

  assign quot   = qq[QW];
  assign rem_nz = |r[QW];
  assign ovf    = ov[QW];

endmodule
`default_nettype wire

/* design/sit_back.sv */
`default_nettype none
module sit_back #(
  parameter int COORD_BITS = sit_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = sit_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              empty,
  output logic                              pop,
  input  sit_pkg::sit_ctrl_t                ctrl_in,
  input  logic [sit_pkg::entry_w(COORD_BITS)-1:0] entry,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              hit,
  output logic                              point_valid,
  output logic signed [sit_pkg::Q_BITS-1:0] qx,
  output logic signed [sit_pkg::Q_BITS-1:0] qy
);
  import sit_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int DW = CW + 1;
  localparam int NW = num_w(CW);
  localparam int NL = (NW + 1) / 2;
  localparam int NH = NW - NL;
  localparam int QW = quo_w(CW, FRAC_BITS);
  localparam int XW = QW + NW;
  localparam int TW = QW + 2;
  localparam int SW = ((CW + FRAC_BITS) > TW ? CW + FRAC_BITS : TW) + 1;
  localparam logic signed [TW-1:0] SAT_T = {2'b01, {QW{1'b0}}};

  logic en;
  assign en  = !(result_valid && result_stall);
  assign pop = en && !empty;

  logic signed [CW-1:0] e_bx, e_by;
  logic signed [DW-1:0] e_dirx, e_diry;
  logic signed [NW-1:0] e_num, e_det;
  assign {e_bx, e_by, e_dirx, e_diry, e_num, e_det} = entry;

  logic      b0_v, b1_v, b2_v, b3_v;
  sit_ctrl_t b0_ctrl, b1_ctrl, b2_ctrl, b3_ctrl;
  logic signed [CW-1:0] b0_bx, b0_by, b1_bx, b1_by, b2_bx, b2_by, b3_bx, b3_by;
  logic signed [DW-1:0] b0_dirx, b0_diry;
  logic signed [NW-1:0] b0_num, b0_det;
  logic [DW-1:0]        b1_mdx, b1_mdy;
  logic [NW-1:0]        b1_mn, b1_md, b2_md, b3_md;
  logic                 b1_negx, b1_negy, b2_negx, b2_negy, b3_negx, b3_negy;
  logic [DW+NL-1:0]     b2_pxl, b2_pyl;
  logic [DW+NH-1:0]     b2_pxh, b2_pyh;
  logic [XW-1:0]        b3_xx, b3_xy;

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_v <= 1'b0;
      b1_v <= 1'b0;
      b2_v <= 1'b0;
      b3_v <= 1'b0;
    end else if (en) begin
      b0_v <= pop;
      b1_v <= b0_v;
      b2_v <= b1_v;
      b3_v <= b2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b0_ctrl <= ctrl_in;
      b0_bx   <= e_bx;
      b0_by   <= e_by;
      b0_dirx <= e_dirx;
      b0_diry <= e_diry;
      b0_num  <= e_num;
      b0_det  <= e_det;
      // magnitudes and result signs
      b1_ctrl <= b0_ctrl;
      b1_bx   <= b0_bx;
      b1_by   <= b0_by;
      b1_mdx  <= b0_dirx[DW-1] ? DW'(-b0_dirx) : DW'(b0_dirx);
      b1_mdy  <= b0_diry[DW-1] ? DW'(-b0_diry) : DW'(b0_diry);
      b1_mn   <= b0_num[NW-1] ? NW'(-b0_num) : NW'(b0_num);
      b1_md   <= b0_det[NW-1] ? NW'(-b0_det) : NW'(b0_det);
      b1_negx <= b0_dirx[DW-1] ^ b0_num[NW-1] ^ b0_det[NW-1];
      b1_negy <= b0_diry[DW-1] ^ b0_num[NW-1] ^ b0_det[NW-1];
      // split products
      b2_ctrl <= b1_ctrl;
      b2_bx   <= b1_bx;
      b2_by   <= b1_by;
      b2_md   <= b1_md;
      b2_negx <= b1_negx;
      b2_negy <= b1_negy;
      b2_pxl  <= b1_mdx * b1_mn[NL-1:0];
      b2_pxh  <= b1_mdx * b1_mn[NW-1:NL];
      b2_pyl  <= b1_mdy * b1_mn[NL-1:0];
      b2_pyh  <= b1_mdy * b1_mn[NW-1:NL];
      // scaled dividends
      b3_ctrl <= b2_ctrl;
      b3_bx   <= b2_bx;
      b3_by   <= b2_by;
      b3_md   <= b2_md;
      b3_negx <= b2_negx;
      b3_negy <= b2_negy;
      b3_xx   <= (XW'(b2_pxh) << (NL + FRAC_BITS)) + (XW'(b2_pxl) << FRAC_BITS);
      b3_xy   <= (XW'(b2_pyh) << (NL + FRAC_BITS)) + (XW'(b2_pyl) << FRAC_BITS);
    end
  end

  logic [QW-1:0] quo_x, quo_y;
  logic          rnz_x, rnz_y, ovf_x, ovf_y;

  sit_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_x (
    .clk(clk), .en(en), .dividend(b3_xx), .divisor(b3_md),
    .quot(quo_x), .rem_nz(rnz_x), .ovf(ovf_x)
  );

  sit_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_y (
    .clk(clk), .en(en), .dividend(b3_xy), .divisor(b3_md),
    .quot(quo_y), .rem_nz(rnz_y), .ovf(ovf_y)
  );

  // side data alongside the divider stages
  logic                 sd_v    [QW+1];
  sit_ctrl_t            sd_ctrl [QW+1];
  logic signed [CW-1:0] sd_bx   [QW+1];
  logic signed [CW-1:0] sd_by   [QW+1];
  logic                 sd_negx [QW+1];
  logic                 sd_negy [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QW; k++) begin
        sd_v[k] <= 1'b0;
      end
    end else if (en) begin
      sd_v[0] <= b3_v;
      for (int k = 1; k <= QW; k++) begin
        sd_v[k] <= sd_v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_ctrl[0] <= b3_ctrl;
      sd_bx[0]   <= b3_bx;
      sd_by[0]   <= b3_by;
      sd_negx[0] <= b3_negx;
      sd_negy[0] <= b3_negy;
      for (int k = 1; k <= QW; k++) begin
        sd_ctrl[k] <= sd_ctrl[k-1];
        sd_bx[k]   <= sd_bx[k-1];
        sd_by[k]   <= sd_by[k-1];
        sd_negx[k] <= sd_negx[k-1];
        sd_negy[k] <= sd_negy[k-1];
      end
    end
  end

  function automatic logic signed [Q_BITS-1:0] sat_q(input logic signed [SW-1:0] v);
    logic [SW-Q_BITS:0] top;
    top = v[SW-1:Q_BITS-1];
    if (top == '0 || top == '1) begin
      return v[Q_BITS-1:0];
    end else if (v[SW-1]) begin
      return {1'b1, {(Q_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(Q_BITS-1){1'b1}}};
    end
  endfunction

  logic signed [TW-1:0] qs_x, qs_y, t_x, t_y;
  logic signed [SW-1:0] sum_x, sum_y;
  logic                 is_div, has_pt;

  assign qs_x = TW'(quo_x);
  assign qs_y = TW'(quo_y);
  assign t_x  = ovf_x ? (sd_negx[QW] ? -SAT_T : SAT_T)
                      : (sd_negx[QW] ? -qs_x - TW'(rnz_x) : qs_x);
  assign t_y  = ovf_y ? (sd_negy[QW] ? -SAT_T : SAT_T)
                      : (sd_negy[QW] ? -qs_y - TW'(rnz_y) : qs_y);
  assign is_div = (sd_ctrl[QW].kind == KIND_DIV);
  assign has_pt = is_div || (sd_ctrl[QW].kind == KIND_POINT);
  assign sum_x  = (SW'(sd_bx[QW]) <<< FRAC_BITS) + (is_div ? SW'(t_x) : '0);
  assign sum_y  = (SW'(sd_by[QW]) <<< FRAC_BITS) + (is_div ? SW'(t_y) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= sd_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit         <= sd_ctrl[QW].hit;
      point_valid <= has_pt;
      qx          <= has_pt ? sat_q(sum_x) : '0;
      qy          <= has_pt ? sat_q(sum_y) : '0;
    end
  end

endmodule
`default_nettype wire

/* design/segment_intersection_test_2d_top.sv */
// Segment pair intersection test.
// Input channel: item_valid / item_stall with the endpoints A, B, C, D and
// want_point. An item is taken at a clock edge with item_valid high and
// item_stall low. Output channel: result_valid / result_stall with hit,
// point_valid and the point qx, qy (FRAC_BITS fraction bits, saturated).
// Throughput: one item per cycle, sustained, while the receiver takes results.
// The crossing point is computed by a pipelined restoring divider, one quotient
// bit per stage. A three-stage front end classifies each item and writes it
// to a small queue; the back end computes the point. When result_stall is
// high while result_valid is high the back end holds, the queue fills, and
// then item_stall rises until room returns.
// Reset (rst, synchronous) empties the pipelines and the queue; the first item
// may be offered in the cycle after reset is released.
`default_nettype none
module segment_intersection_test_2d_top #(
  parameter int COORD_BITS  = sit_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS   = sit_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = sit_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic signed [COORD_BITS-1:0]      ax,
  input  logic signed [COORD_BITS-1:0]      ay,
  input  logic signed [COORD_BITS-1:0]      bx,
  input  logic signed [COORD_BITS-1:0]      by,
  input  logic signed [COORD_BITS-1:0]      cx,
  input  logic signed [COORD_BITS-1:0]      cy,
  input  logic signed [COORD_BITS-1:0]      dx,
  input  logic signed [COORD_BITS-1:0]      dy,
  input  logic                              want_point,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              hit,
  output logic                              point_valid,
  output logic signed [sit_pkg::Q_BITS-1:0] qx,
  output logic signed [sit_pkg::Q_BITS-1:0] qy
);
  import sit_pkg::*;

  localparam int EW = entry_w(COORD_BITS);
  localparam int FW = EW + $bits(sit_ctrl_t);

  sit_ctrl_t     f_ctrl;
  logic [EW-1:0] f_entry;
  logic          q_push, q_full, q_pop, q_empty;
  logic [FW-1:0] q_rdata;

  sit_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall),
    .ax(ax), .ay(ay), .bx(bx), .by(by), .cx(cx), .cy(cy), .dx(dx), .dy(dy),
    .want_point(want_point),
    .full(q_full), .push(q_push), .ctrl(f_ctrl), .entry(f_entry)
  );

  sit_fifo #(.WIDTH(FW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .wdata({f_ctrl, f_entry}), .full(q_full),
    .pop(q_pop), .rdata(q_rdata), .empty(q_empty)
  );

  sit_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst),
    .empty(q_empty), .pop(q_pop),
    .ctrl_in(sit_ctrl_t'(q_rdata[FW-1:EW])), .entry(q_rdata[EW-1:0]),
    .result_valid(result_valid), .result_stall(result_stall),
    .hit(hit), .point_valid(point_valid), .qx(qx), .qy(qy)
  );

endmodule
`default_nettype wire

/* tb/segment_intersection_checker.sv */
module segment_intersection_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  input  logic                              item_stall,
  input  logic signed [23:0]                ax,
  input  logic signed [23:0]                ay,
  input  logic signed [23:0]                bx,
  input  logic signed [23:0]                by,
  input  logic signed [23:0]                cx,
  input  logic signed [23:0]                cy,
  input  logic signed [23:0]                dx,
  input  logic signed [23:0]                dy,
  input  logic                              want_point,
  input  logic                              result_valid,
  input  logic                              result_stall,
  input  logic                              hit,
  input  logic                              point_valid,
  input  logic signed [sit_pkg::Q_BITS-1:0] qx,
  input  logic signed [sit_pkg::Q_BITS-1:0] qy,
  output int                                errors,
  output int                                pending
);

  localparam int FB = sit_pkg::FRAC_BITS_DEF;

  typedef struct packed {
    logic        hit;
    logic        point_valid;
    logic [31:0] qx;
    logic [31:0] qy;
  } crossing_t;

  crossing_t crossings_due[$];

  assign pending = crossings_due.size();

  function automatic int orient_sign(longint px, longint py, longint rx, longint ry,
                                     longint sx, longint sy);
    longint c;
    c = (rx - px) * (sy - py) - (ry - py) * (sx - px);
    return (c > 0) ? 1 : ((c < 0) ? -1 : 0);
  endfunction

  function automatic logic [31:0] sat32(logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'h7fffffff;
    if (v < -128'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] axis_coord(longint base, longint dir, longint num,
                                             longint det);
    logic signed [127:0] n, d, q, r;
    n = ($signed(128'(dir)) * $signed(128'(num))) <<< FB;
    d = det;
    q = n / d;
    r = n % d;
    if (r != 0 && ((r < 0) != (d < 0))) q = q - 1;
    if (q > (128'sd1 <<< 62)) q = 128'sd1 <<< 62;
    if (q < -(128'sd1 <<< 62)) q = -(128'sd1 <<< 62);
    return sat32(($signed(128'(base)) <<< FB) + q);
  endfunction

  function automatic crossing_t predict_crossing(longint pax, longint pay, longint pbx,
                                                 longint pby, longint pcx, longint pcy,
                                                 longint pdx, longint pdy, logic want);
    crossing_t e;
    int s1, s2, s3, s4, i, j;
    longint xs[4], ys[4], t, det, num;
    logic xa, ya, eac, ebd, ead, ebc;
    e = '0;
    s1 = orient_sign(pax, pay, pbx, pby, pcx, pcy);
    s2 = orient_sign(pbx, pby, pcx, pcy, pdx, pdy);
    s3 = orient_sign(pax, pay, pbx, pby, pdx, pdy);
    s4 = orient_sign(pax, pay, pcx, pcy, pdx, pdy);
    if (s1 == 0 && s2 == 0 && s3 == 0 && s4 == 0) begin
      xa = ((pax > pbx ? pax : pbx) <= (pcx < pdx ? pcx : pdx)) ||
           ((pax < pbx ? pax : pbx) >= (pcx > pdx ? pcx : pdx));
      ya = ((pay > pby ? pay : pby) <= (pcy < pdy ? pcy : pdy)) ||
           ((pay < pby ? pay : pby) >= (pcy > pdy ? pcy : pdy));
      if (!(xa && ya)) begin
        xs = '{pax, pbx, pcx, pdx};
        ys = '{pay, pby, pcy, pdy};
        for (i = 1; i < 4; i++)
          for (j = i; j > 0; j--)
            if (xs[j] < xs[j-1] || (xs[j] == xs[j-1] && ys[j] < ys[j-1])) begin
              t = xs[j]; xs[j] = xs[j-1]; xs[j-1] = t;
              t = ys[j]; ys[j] = ys[j-1]; ys[j-1] = t;
            end
        e.hit = 1'b1;
        e.point_valid = 1'b1;
        e.qx = sat32(128'(xs[1]) <<< FB);
        e.qy = sat32(128'(ys[1]) <<< FB);
      end
    end else begin
      eac = pax == pcx && pay == pcy;
      ebd = pbx == pdx && pby == pdy;
      ead = pax == pdx && pay == pdy;
      ebc = pbx == pcx && pby == pcy;
      if (eac == ebd && ead == ebc) begin
        e.hit = (s1 != s3) && (s2 != s4);
        if (want) begin
          det = (pbx - pax) * (pcy - pdy) - (pcx - pdx) * (pby - pay);
          num = (pcx - pax) * (pcy - pdy) - (pcx - pdx) * (pcy - pay);
          if (det != 0) begin
            e.point_valid = 1'b1;
            e.qx = axis_coord(pax, pbx - pax, num, det);
            e.qy = axis_coord(pay, pby - pay, num, det);
          end
        end
      end
    end
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  initial errors = 0;

  always @(posedge clk) begin
    crossing_t e;
    if (!rst) begin
      if (item_valid && !item_stall)
        crossings_due.push_back(predict_crossing(ax, ay, bx, by, cx, cy, dx, dy,
                                                 want_point));
      if (result_valid && !result_stall) begin
        if (crossings_due.size() == 0) begin
          report_mismatch("unexpected item", 0, 0);
        end else begin
          e = crossings_due.pop_front();
          if (hit !== e.hit) report_mismatch("hit", hit, e.hit);
          if (point_valid !== e.point_valid)
            report_mismatch("point_valid", point_valid, e.point_valid);
          if (qx !== e.qx) report_mismatch("qx", qx, e.qx);
          if (qy !== e.qy) report_mismatch("qy", qy, e.qy);
        end
      end
    end
  end

endmodule

/* tb/segment_intersection_test_2d_top_tb.sv */
module segment_intersection_test_2d_top_tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic signed [23:0] ax = '0, ay = '0, bx = '0, by = '0;
  logic signed [23:0] cx = '0, cy = '0, dx = '0, dy = '0;
  logic want_point = 1'b0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic hit, point_valid;
  logic signed [31:0] qx, qy;
  int errors, pending;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;

  always #10 clk = ~clk;

  segment_intersection_test_2d_top dut (.*);
  segment_intersection_checker chk (.*);

  function automatic logic [23:0] rand_coord(int mode);
    case (mode)
      0: return 24'($signed($urandom_range(0, 40)) - 20);
      1: return 24'($urandom);
      2: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
      default: return 24'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  task automatic send_pair(logic [23:0] pax, pay, pbx, pby, pcx, pcy, pdx, pdy,
                           logic want);
    ax <= pax; ay <= pay; bx <= pbx; by <= pby;
    cx <= pcx; cy <= pcy; dx <= pdx; dy <= pdy;
    want_point <= want;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic send_random(int k);
    logic [23:0] c[8];
    int mode, s;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < 8; i++) c[i] = rand_coord(mode);
    case ($urandom_range(0, 5))
      0: begin
        s = $urandom_range(1, 4);
        c[4] = c[0] + 24'(s * ($signed(c[2]) - $signed(c[0])) / 4);
        c[5] = c[1] + 24'(s * ($signed(c[3]) - $signed(c[1])) / 4);
        c[6] = c[0] + 24'(($signed(c[2]) - $signed(c[0])) * 3);
        c[7] = c[1] + 24'(($signed(c[3]) - $signed(c[1])) * 3);
      end
      1: begin c[4] = c[0]; c[5] = c[1]; end
      2: begin c[6] = c[2]; c[7] = c[3]; c[4] = c[0]; c[5] = c[1]; end
      default: ;
    endcase
    send_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], 1'($urandom));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_pair(0, 0, 10, 10, 0, 10, 10, 0, 1);
    send_pair(0, 0, 10, 10, 0, 10, 10, 0, 0);
    send_pair(0, 0, 10, 0, 5, 0, 20, 0, 1);
    send_pair(0, 0, 10, 0, 10, 0, 20, 0, 1);
    send_pair(0, 0, 10, 0, 20, 0, 30, 0, 0);
    send_pair(0, 0, 10, 10, 10, 10, 20, 0, 1);
    send_pair(0, 0, 10, 10, 10, 10, 0, 0, 1);
    send_pair(0, 0, 10, 10, 0, 0, 10, 10, 1);
    send_pair(0, 0, 10, 0, 0, 5, 10, 5, 1);
    send_pair(0, 0, 1, 0, 5, 5, 5, 6, 1);
    send_pair(24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff,
              24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000, 1);
    send_pair(24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff,
              24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000, 1);
    send_pair(0, 0, 24'h7fffff, 1, 1, 24'h800000, 2, 24'h7fffff, 1);
    send_pair(24'h800000, 0, 24'h7fffff, 0, 24'h800001, 0, 24'h7ffffe, 0, 0);
    send_pair(0, 0, 3, 7, 1, 0, 0, 1, 1);
    send_pair(5, 5, 5, 5, 5, 5, 5, 5, 1);
    for (int k = 0; k < 1500; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        item_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      if (k == 700) hold_off = 1'b1;
      send_random(k);
    end
    item_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    int phase;
    phase = 0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        result_stall <= 1'b1;
        repeat (150) @(posedge clk);
        hold_off = 1'b0;
        result_stall <= 1'b0;
      end else begin
        phase++;
        result_stall <= (phase % 200 < 60) ? 1'b0 : ($urandom_range(0, 3) == 0);
      end
    end
  end

  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* segment_intersection_test_2d_top.f */
+incdir+design
design/sit_pkg.sv
design/sit_fifo.sv
design/sit_front.sv
design/sit_div.sv
design/sit_back.sv
design/segment_intersection_test_2d_top.sv
tb/segment_intersection_checker.sv
tb/segment_intersection_test_2d_top_tb.sv
